>>> rtl/tcw_pkg.sv
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = 16;

    // Widths of the row and column fields on the ports.
    localparam int FROW_W = 5;
    localparam int FCOL_W = 7;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_READ,
        S_DONE
    } t_state;

    // One write port and one read port of the screen memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [CELL_W-1:0] make_cell(input logic [3:0] fg,
                                                    input logic [3:0] bg,
                                                    input logic [7:0] ch);
        return {bg, fg, ch};
    endfunction

    // Logical row to memory row, given the row that currently sits at the top.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] s;
        s = {1'b0, row} + {1'b0, top};
        if (s >= (ROW_W + 1)'(ROWS)) begin
            s = s - (ROW_W + 1)'(ROWS);
        end
        return ROW_W'(s);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

>>> rtl/text_console_writer.sv
// Channel   Dir  Handshake                 Payload
// s (cmd)   in   i_s_tvalid / o_s_tready   i_s_tdata[19:0], i_s_tuser[1:0] (opcode)
// m (res)   out  o_m_tvalid / i_m_tready   o_m_tdata[27:0]
// cfg       in   i_cfg_we                  i_cfg_index, i_cfg_data[3:0]
//
// One item is worked on at a time. A put, a newline, an off-screen read or
// the unused opcode passes from acceptance through the execute and done
// states before the block returns to idle; a read on the screen adds a state
// for the memory access. A put or newline that runs past the last row adds
// a sweep that blanks one row, and a clear sweeps the whole screen. Both
// sweeps are paced by the single write port of the screen memory, which
// writes one cell a cycle.
// Scrolling moves no cells: a top-row pointer rotates and only the new
// bottom row is rewritten. Reset clears the cursor and the pointer and
// returns the colours to their reset values; the screen itself is undefined
// until a clear. A stalled result holds in the output register; the next
// item may still be taken and worked on, but it waits before its own result
// can move up, and the block takes no further item until then.
module text_console_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] character, [12:8] cell_row, [19:13] cell_column, [23:20] zero
    input  logic [23:0] i_s_tdata,
    // [1:0] opcode
    input  logic [1:0]  i_s_tuser,

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] cell_value, [20:16] cursor_row, [27:21] cursor_column, [31:28] zero
    output logic [31:0] o_m_tdata,

    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int CELL_W = tcw_pkg::CELL_W;
    localparam int FROW_W = tcw_pkg::FROW_W;
    localparam int FCOL_W = tcw_pkg::FCOL_W;

    tcw_pkg::t_state r_state, n_state;

    // Colour registers.
    logic [3:0] r_fg, r_bg;

    // Cursor and the memory row that shows as row 0.
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_top, n_top;

    // The item being worked on.
    logic [1:0]        r_op, n_op;
    logic [7:0]        r_ch, n_ch;
    logic [FROW_W-1:0] r_rd_row, n_rd_row;
    logic [FCOL_W-1:0] r_rd_col, n_rd_col;

    // Fill sweep over a row or over the whole screen.
    logic [ADDR_W-1:0] r_sweep_addr, n_sweep_addr;
    logic [ADDR_W-1:0] r_sweep_last, n_sweep_last;

    logic [CELL_W-1:0] r_value, n_value;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [CELL_W-1:0] r_out_value, n_out_value;
    logic [FROW_W-1:0] r_out_row, n_out_row;
    logic [FCOL_W-1:0] r_out_col, n_out_col;

    tcw_pkg::t_ram_req ram_req;
    logic [CELL_W-1:0] ram_rdata;
    logic              rd_ok;

    tcw_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == tcw_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_col, r_out_row, r_out_value};

    // A read outside the screen returns zero and touches nothing.
    assign rd_ok = (int'(r_rd_row) < tcw_pkg::ROWS) && (int'(r_rd_col) < tcw_pkg::COLUMNS);

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_top        = r_top;
        n_op         = r_op;
        n_ch         = r_ch;
        n_rd_row     = r_rd_row;
        n_rd_col     = r_rd_col;
        n_sweep_addr = r_sweep_addr;
        n_sweep_last = r_sweep_last;
        n_value      = r_value;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;

        ram_req.we    = 1'b0;
        ram_req.waddr = tcw_pkg::cell_addr(tcw_pkg::phys_row(r_row, r_top), r_col);
        ram_req.wdata = tcw_pkg::make_cell(r_fg, r_bg, r_ch);
        ram_req.re    = 1'b0;
        ram_req.raddr = tcw_pkg::cell_addr(tcw_pkg::phys_row(ROW_W'(r_rd_row), r_top),
                                           COL_W'(r_rd_col));

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op     = i_s_tuser;
                    n_ch     = i_s_tdata[7:0];
                    n_rd_row = i_s_tdata[12:8];
                    n_rd_col = i_s_tdata[19:13];
                    n_state  = tcw_pkg::S_EXEC;
                end
            end

            tcw_pkg::S_EXEC: begin
                n_value = '0;
                n_state = tcw_pkg::S_DONE;
                case (r_op)
                    tcw_pkg::OP_PUT: begin
                        ram_req.we = (r_ch != tcw_pkg::CHAR_NEWLINE);
                        if (r_ch == tcw_pkg::CHAR_NEWLINE
                            || r_col == COL_W'(tcw_pkg::COLUMNS - 1)) begin
                            n_col = '0;
                            if (r_row == ROW_W'(tcw_pkg::ROWS - 1)) begin
                                // Scroll: the old top row becomes the new
                                // bottom row and is blanked.
                                n_sweep_addr = tcw_pkg::cell_addr(r_top, '0);
                                n_sweep_last = tcw_pkg::cell_addr(r_top,
                                                   COL_W'(tcw_pkg::COLUMNS - 1));
                                n_top = (r_top == ROW_W'(tcw_pkg::ROWS - 1))
                                        ? '0 : r_top + 1'b1;
                                n_state = tcw_pkg::S_SWEEP;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                    tcw_pkg::OP_CLEAR: begin
                        n_sweep_addr = '0;
                        n_sweep_last = ADDR_W'(tcw_pkg::CELLS - 1);
                        n_top        = '0;
                        n_row        = '0;
                        n_col        = '0;
                        n_state      = tcw_pkg::S_SWEEP;
                    end
                    tcw_pkg::OP_READ: begin
                        if (rd_ok) begin
                            ram_req.re = 1'b1;
                            n_state    = tcw_pkg::S_READ;
                        end
                    end
                    default: begin
                        // The unused opcode only reports the cursor.
                    end
                endcase
            end

            tcw_pkg::S_SWEEP: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_sweep_addr;
                ram_req.wdata = tcw_pkg::make_cell(r_fg, r_bg, tcw_pkg::CHAR_SPACE);
                if (r_sweep_addr == r_sweep_last) begin
                    n_state = tcw_pkg::S_DONE;
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end

            tcw_pkg::S_READ: begin
                n_value = ram_rdata;
                n_state = tcw_pkg::S_DONE;
            end

            tcw_pkg::S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_value;
                    n_out_row   = FROW_W'(r_row);
                    n_out_col   = FCOL_W'(r_col);
                    n_state     = tcw_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
            r_fg        <= 4'd2;
            r_bg        <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tcw_pkg::CFG_FG: r_fg <= i_cfg_data;
                    tcw_pkg::CFG_BG: r_bg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_ch         <= n_ch;
        r_rd_row     <= n_rd_row;
        r_rd_col     <= n_rd_col;
        r_sweep_addr <= n_sweep_addr;
        r_sweep_last <= n_sweep_last;
        r_value      <= n_value;
        r_out_value  <= n_out_value;
        r_out_row    <= n_out_row;
        r_out_col    <= n_out_col;
    end

endmodule

>>> rtl/tcw_ram.sv
module tcw_ram (
    input  logic                        i_clk,
    input  tcw_pkg::t_ram_req           i_req,
    output logic [tcw_pkg::CELL_W-1:0]  o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule

>>> rtl/tcw_checker.sv
module tcw_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    // A result that is not taken keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // The reported cursor always lies on the screen.
    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (int'(o_m_tdata[20:16]) < tcw_pkg::ROWS)
                    && (int'(o_m_tdata[27:21]) < tcw_pkg::COLUMNS))
        else $error("cursor off the screen");

    // Items are worked on one at a time.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item accepted while another is at work");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result present after reset");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
